>>> hdl/grc_pkg.sv
// Shared types, constants and the CORDIC angle table for the grid ray caster.
package grc_pkg;

    localparam int TURN         = 5760;
    localparam int HALF_TURN    = 2880;
    localparam int QUARTER_TURN = 1440;
    localparam int ANG_W        = 13;
    localparam int COORD_W      = 16;
    localparam int COL_W        = 6;
    localparam int CELL_SHIFT   = 13;
    localparam int CELL         = 8192;
    localparam int TRIG_W       = 18;
    localparam int DIVN_W       = 30;
    localparam int DIVD_W       = 17;
    localparam int DIST_W       = 16;
    localparam int HGT_MAX_W    = 11;
    localparam int OFS_MAX_W    = 10;
    localparam int CORDIC_X0    = 39797;

    typedef struct packed {
        logic [COL_W-1:0]   k;
        logic [ANG_W-1:0]   ra;
        logic [ANG_W-1:0]   corr;
        logic [COORD_W-1:0] px;
        logic [COORD_W-1:0] py;
        logic               last;
    } ray_desc_t;

    typedef struct packed {
        logic [COL_W-1:0]     column;
        logic [COORD_W-1:0]   hit_x;
        logic [COORD_W-1:0]   hit_y;
        logic [DIST_W-1:0]    distance;
        logic                 hit_found;
        logic                 vertical_side;
        logic [HGT_MAX_W-1:0] wall_height;
        logic [OFS_MAX_W-1:0] wall_offset;
        logic                 last;
    } ray_result_t;

    typedef struct packed {
        logic             start;
        logic [ANG_W-1:0] angle;
    } cordic_req_t;

    typedef struct packed {
        logic                     done;
        logic signed [TRIG_W-1:0] cs;
        logic signed [TRIG_W-1:0] sn;
    } cordic_rsp_t;

    typedef struct packed {
        logic              start;
        logic [DIVN_W-1:0] num;
        logic [DIVD_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DIVN_W-1:0] quo;
        logic [DIVD_W-1:0] rem;
    } div_rsp_t;

    // atan(2^-i) in sixteenth degrees, 16 fraction bits
    function automatic logic [26:0] atan_step(input logic [3:0] i);
        logic [26:0] v;
        begin
            case (i)
                4'd0:    v = 27'd47185920;
                4'd1:    v = 27'd27855475;
                4'd2:    v = 27'd14718068;
                4'd3:    v = 27'd7471121;
                4'd4:    v = 27'd3750058;
                4'd5:    v = 27'd1876857;
                4'd6:    v = 27'd938658;
                4'd7:    v = 27'd469358;
                4'd8:    v = 27'd234682;
                4'd9:    v = 27'd117342;
                4'd10:   v = 27'd58671;
                4'd11:   v = 27'd29335;
                4'd12:   v = 27'd14668;
                4'd13:   v = 27'd7334;
                4'd14:   v = 27'd3667;
                4'd15:   v = 27'd1834;
                default: v = 27'd0;
            endcase
            return v;
        end
    endfunction

endpackage

>>> hdl/grc_fifo.sv
// Small register queue used between the front, the back and the result port.
module grc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [AW:0]      count_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == (AW+1)'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

>>> hdl/grc_front.sv
// Front end: take a frame request and hand out one ray descriptor per column.
module grc_front import grc_pkg::*; #(
    parameter int RAY_COUNT = 60
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [COORD_W-1:0] player_x,
    input  logic [COORD_W-1:0] player_y,
    input  logic [ANG_W-1:0]   view_angle,
    output logic               rq_push,
    output ray_desc_t          rq_data,
    input  logic               rq_full
);

    logic               active_reg;
    logic [COL_W-1:0]   k_reg;
    logic [ANG_W-1:0]   ra_reg;
    logic [ANG_W-1:0]   corr_reg;
    logic [COORD_W-1:0] px_reg;
    logic [COORD_W-1:0] py_reg;

    logic [ANG_W-1:0] view_mod;
    logic [ANG_W:0]   ra_first;
    logic [ANG_W:0]   ra_sum;
    logic             is_last;

    assign full    = active_reg;
    assign is_last = (k_reg == COL_W'(RAY_COUNT - 1));
    assign rq_push = active_reg && !rq_full;

    always_comb
    begin
        view_mod = (view_angle >= ANG_W'(TURN)) ? view_angle - ANG_W'(TURN) : view_angle;
        ra_first = {1'b0, view_mod} + (ANG_W+1)'(TURN - 480);
        if (ra_first >= (ANG_W+1)'(TURN))
        begin
            ra_first = ra_first - (ANG_W+1)'(TURN);
        end
        ra_sum = {1'b0, ra_reg} + (ANG_W+1)'(16);
        if (ra_sum >= (ANG_W+1)'(TURN))
        begin
            ra_sum = ra_sum - (ANG_W+1)'(TURN);
        end
        rq_data.k    = k_reg;
        rq_data.ra   = ra_reg;
        rq_data.corr = corr_reg;
        rq_data.px   = px_reg;
        rq_data.py   = py_reg;
        rq_data.last = is_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            k_reg      <= '0;
        end
        else if (push && !active_reg)
        begin
            active_reg <= 1'b1;
            k_reg      <= '0;
        end
        else if (rq_push)
        begin
            k_reg <= k_reg + 1'b1;
            if (is_last)
            begin
                active_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && !active_reg)
        begin
            px_reg   <= player_x;
            py_reg   <= player_y;
            ra_reg   <= ra_first[ANG_W-1:0];
            corr_reg <= ANG_W'(480);
        end
        else if (rq_push)
        begin
            ra_reg   <= ra_sum[ANG_W-1:0];
            corr_reg <= (corr_reg < ANG_W'(16)) ? corr_reg + ANG_W'(TURN - 16)
                                                : corr_reg - ANG_W'(16);
        end
    end

endmodule

>>> hdl/grc_cordic.sv
// Iterative rotation CORDIC, one micro-rotation per cycle, cosine and sine in Q16.
module grc_cordic import grc_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  cordic_req_t req,
    output cordic_rsp_t rsp
);

    localparam int XW = 20;
    localparam int ZW = 30;

    logic signed [XW-1:0] x_reg;
    logic signed [XW-1:0] y_reg;
    logic signed [ZW-1:0] z_reg;
    logic [3:0]           it_reg;
    logic                 busy_reg;
    logic                 neg_reg;
    logic                 done_reg;

    logic signed [14:0]   a_f;
    logic                 a_neg;
    logic signed [ZW-1:0] z_init;
    logic signed [XW-1:0] xs;
    logic signed [XW-1:0] ys;
    logic signed [ZW-1:0] at;
    logic signed [XW-1:0] neg_x;
    logic signed [XW-1:0] neg_y;

    always_comb
    begin
        a_f   = $signed({2'b00, req.angle});
        a_neg = 1'b0;
        if (a_f >= 15'sd2880)
        begin
            a_f = a_f - 15'sd5760;
        end
        if (a_f > 15'sd1440)
        begin
            a_f   = a_f - 15'sd2880;
            a_neg = 1'b1;
        end
        else if (a_f < -15'sd1440)
        begin
            a_f   = a_f + 15'sd2880;
            a_neg = 1'b1;
        end
        z_init = ZW'(a_f) <<< 16;
        xs     = x_reg >>> it_reg;
        ys     = y_reg >>> it_reg;
        at     = $signed({3'b000, atan_step(it_reg)});
        neg_x  = -x_reg;
        neg_y  = -y_reg;
    end

    assign rsp.done = done_reg;
    assign rsp.cs   = neg_reg ? TRIG_W'(neg_x) : TRIG_W'(x_reg);
    assign rsp.sn   = neg_reg ? TRIG_W'(neg_y) : TRIG_W'(y_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            it_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                it_reg   <= '0;
            end
            else if (busy_reg)
            begin
                it_reg <= it_reg + 1'b1;
                if (it_reg == 4'd15)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            x_reg   <= XW'(CORDIC_X0);
            y_reg   <= '0;
            z_reg   <= z_init;
            neg_reg <= a_neg;
        end
        else if (busy_reg)
        begin
            if (z_reg >= 0)
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - at;
            end
            else
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + at;
            end
        end
    end

endmodule

>>> hdl/grc_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module grc_div import grc_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int CW = $clog2(DIVN_W);

    logic [DIVN_W-1:0] q_reg;
    logic [DIVD_W-1:0] r_reg;
    logic [DIVD_W-1:0] d_reg;
    logic [CW-1:0]     cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [DIVD_W:0]   r_sh;
    logic [DIVD_W:0]   diff;
    logic              ge;

    always_comb
    begin
        r_sh = {r_reg, q_reg[DIVN_W-1]};
        diff = r_sh - {1'b0, d_reg};
        ge   = (r_sh >= {1'b0, d_reg});
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = q_reg;
    assign rsp.rem  = r_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(DIVN_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            q_reg <= req.num;
            r_reg <= '0;
            d_reg <= req.den;
        end
        else if (busy_reg)
        begin
            q_reg <= {q_reg[DIVN_W-2:0], ge};
            r_reg <= ge ? diff[DIVD_W-1:0] : r_sh[DIVD_W-1:0];
        end
    end

endmodule

>>> hdl/grc_back.sv
// Back end: trace one ray at a time over the wall map and build its result.
module grc_back import grc_pkg::*; #(
    parameter int MAP_WIDTH   = 8,
    parameter int MAP_HEIGHT  = 8,
    parameter int MAX_STEPS   = 8,
    parameter int VIEW_HEIGHT = 320
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic [63:0] map_walls,
    input  logic        rq_empty,
    input  ray_desc_t   rq_data,
    output logic        rq_pop,
    input  logic        oq_full,
    output logic        oq_push,
    output ray_result_t oq_data
);

    localparam int STEP_W = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
    localparam int UW     = 20;
    localparam int WW     = 38;
    localparam int QW     = 36;
    localparam int SQW    = 34;
    localparam logic signed [WW-1:0] X_LIM   = WW'(MAP_WIDTH * CELL);
    localparam logic signed [WW-1:0] Y_LIM   = WW'(MAP_HEIGHT * CELL);
    localparam logic [DIVN_W-1:0]    HGT_NUM = DIVN_W'(4096 * VIEW_HEIGHT);

    typedef enum logic [3:0] {
        S_IDLE, S_TRIG, S_WSET, S_WMUL, S_DIVA, S_DIVB, S_WSTEP, S_WNEXT,
        S_SQMUL, S_SQADD, S_PICK, S_CORR, S_ROOT, S_SCALE, S_HDIV, S_EMIT
    } state_t;

    state_t state_reg;

    ray_desc_t                desc_reg;
    logic signed [TRIG_W-1:0] cs_reg;
    logic signed [TRIG_W-1:0] sn_reg;
    logic                     vert_reg;
    logic [COORD_W-1:0]       pw_reg;
    logic signed [UW-1:0]     u_reg;
    logic                     fwd_reg;
    logic                     neg_reg;
    logic [13:0]              d0_reg;
    logic [DIVD_W-1:0]        num_abs_reg;
    logic [DIVD_W-1:0]        den_abs_reg;
    logic [QW-1:0]            q_reg;
    logic [DIVD_W-1:0]        r_reg;
    logic [DIVN_W-1:0]        qb_reg;
    logic [DIVD_W-1:0]        rb_reg;
    logic [STEP_W-1:0]        step_reg;
    logic                     hh_reg;
    logic                     vh_reg;
    logic [COORD_W-1:0]       hx_reg;
    logic [COORD_W-1:0]       hy_reg;
    logic [COORD_W-1:0]       vx_reg;
    logic [COORD_W-1:0]       vy_reg;
    logic [1:0]               sq_idx_reg;
    logic [31:0]              prod_reg;
    logic [SQW-1:0]           sqh_reg;
    logic [SQW-1:0]           sqv_reg;
    logic [SQW-1:0]           rv_reg;
    logic [SQW-1:0]           rr_reg;
    logic [SQW-1:0]           rbit_reg;
    logic [DIVD_W-1:0]        cc_reg;
    logic                     found_reg;
    logic                     vside_reg;
    logic [COORD_W-1:0]       rx_reg;
    logic [COORD_W-1:0]       ry_reg;
    logic [DIST_W-1:0]        dist_reg;
    logic [HGT_MAX_W-1:0]     height_reg;
    logic                     cor_start_reg;
    logic [ANG_W-1:0]         cor_angle_reg;
    logic                     div_start_reg;
    logic [DIVN_W-1:0]        div_num_reg;
    logic [DIVD_W-1:0]        div_den_reg;

    cordic_req_t cor_req;
    div_req_t    div_req;
    cordic_rsp_t cor_rsp;
    div_rsp_t    div_rsp;

    assign cor_req = {cor_start_reg, cor_angle_reg};
    assign div_req = {div_start_reg, div_num_reg, div_den_reg};

    grc_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (cor_req),
        .rsp   (cor_rsp)
    );

    grc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // walk setup
    logic signed [TRIG_W-1:0] num_sel;
    logic signed [TRIG_W-1:0] den_sel;
    logic signed [TRIG_W-1:0] num_neg;
    logic signed [TRIG_W-1:0] den_neg;
    logic [COORD_W-1:0]       pu_sel;
    logic [COORD_W-1:0]       pw_sel;
    logic [COORD_W-1:0]       base;
    logic                     allow;
    logic                     fwd;
    logic signed [UW-1:0]     u0;
    logic [13:0]              d0;

    always_comb
    begin
        if (!vert_reg)
        begin
            allow  = (desc_reg.ra != '0) && (desc_reg.ra != ANG_W'(HALF_TURN))
                     && (sn_reg != '0);
            fwd    = (desc_reg.ra < ANG_W'(HALF_TURN));
            pu_sel = desc_reg.py;
            pw_sel = desc_reg.px;
            num_sel = cs_reg;
            den_sel = sn_reg;
        end
        else
        begin
            allow  = (desc_reg.ra != ANG_W'(QUARTER_TURN))
                     && (desc_reg.ra != ANG_W'(3 * QUARTER_TURN)) && (cs_reg != '0);
            fwd    = !((desc_reg.ra > ANG_W'(QUARTER_TURN))
                       && (desc_reg.ra < ANG_W'(3 * QUARTER_TURN)));
            pu_sel = desc_reg.px;
            pw_sel = desc_reg.py;
            num_sel = sn_reg;
            den_sel = cs_reg;
        end
        num_neg = -num_sel;
        den_neg = -den_sel;
        base    = {pu_sel[COORD_W-1:CELL_SHIFT], {CELL_SHIFT{1'b0}}};
        if (fwd)
        begin
            u0 = $signed({4'b0000, base}) + UW'(CELL);
            d0 = 14'(17'(base) + 17'(CELL) - 17'(pu_sel));
        end
        else
        begin
            u0 = $signed({4'b0000, base}) - UW'(1);
            d0 = 14'(pu_sel - base) + 14'd1;
        end
    end

    // grid step: point on the current line and its wall test
    logic signed [WW-1:0] q_signed;
    logic signed [WW-1:0] w_val;
    logic signed [WW-1:0] u_ext;
    logic signed [WW-1:0] pt_x;
    logic signed [WW-1:0] pt_y;
    logic                 wall;
    logic [DIVD_W:0]      r_sum;
    logic                 carry;
    logic [30:0]          a_prod;

    always_comb
    begin
        q_signed = $signed({2'b00, q_reg});
        if (neg_reg)
        begin
            q_signed = -q_signed;
        end
        w_val = $signed({22'd0, pw_reg}) + q_signed;
        u_ext = WW'(u_reg);
        pt_x  = vert_reg ? u_ext : w_val;
        pt_y  = vert_reg ? w_val : u_ext;
        wall  = (pt_x >= 0) && (pt_y >= 0) && (pt_x < X_LIM) && (pt_y < Y_LIM)
                && map_walls[{pt_y[15:13], pt_x[15:13]}];
        r_sum = {1'b0, r_reg} + {1'b0, rb_reg};
        carry = (r_sum >= {1'b0, den_abs_reg});
        a_prod = 31'(d0_reg) * 31'(num_abs_reg);
    end

    // squared distance terms, root, scaling
    logic [COORD_W-1:0]  sq_a;
    logic [COORD_W-1:0]  sq_b;
    logic signed [16:0]  sq_d;
    logic signed [33:0]  sq_full;
    logic [SQW-1:0]      trial;
    logic [33:0]         dprod;
    logic [16:0]         dshift;

    always_comb
    begin
        case (sq_idx_reg)
            2'd0:    begin sq_a = hx_reg; sq_b = desc_reg.px; end
            2'd1:    begin sq_a = hy_reg; sq_b = desc_reg.py; end
            2'd2:    begin sq_a = vx_reg; sq_b = desc_reg.px; end
            default: begin sq_a = vy_reg; sq_b = desc_reg.py; end
        endcase
        sq_d    = $signed({1'b0, sq_a}) - $signed({1'b0, sq_b});
        sq_full = sq_d * sq_d;
        trial   = rr_reg + rbit_reg;
        dprod   = 34'(rr_reg[16:0]) * 34'(cc_reg);
        dshift  = dprod[33:17];
    end

    assign rq_pop  = (state_reg == S_IDLE) && !rq_empty;
    assign oq_push = (state_reg == S_EMIT) && !oq_full;

    always_comb
    begin
        oq_data.column        = desc_reg.k;
        oq_data.hit_x         = rx_reg;
        oq_data.hit_y         = ry_reg;
        oq_data.distance      = dist_reg;
        oq_data.hit_found     = found_reg;
        oq_data.vertical_side = vside_reg;
        oq_data.wall_height   = height_reg;
        oq_data.wall_offset   = OFS_MAX_W'(VIEW_HEIGHT / 2) - OFS_MAX_W'(height_reg >> 1);
        oq_data.last          = desc_reg.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cor_start_reg <= 1'b0;
            div_start_reg <= 1'b0;
        end
        else
        begin
            cor_start_reg <= 1'b0;
            div_start_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (!rq_empty)
                    begin
                        cor_start_reg <= 1'b1;
                        state_reg     <= S_TRIG;
                    end
                end
                S_TRIG:
                begin
                    if (cor_rsp.done)
                    begin
                        state_reg <= S_WSET;
                    end
                end
                S_WSET:
                begin
                    state_reg <= allow ? S_WMUL : S_WNEXT;
                end
                S_WMUL:
                begin
                    div_start_reg <= 1'b1;
                    state_reg     <= S_DIVA;
                end
                S_DIVA:
                begin
                    if (div_rsp.done)
                    begin
                        div_start_reg <= 1'b1;
                        state_reg     <= S_DIVB;
                    end
                end
                S_DIVB:
                begin
                    if (div_rsp.done)
                    begin
                        state_reg <= S_WSTEP;
                    end
                end
                S_WSTEP:
                begin
                    if (wall || step_reg == STEP_W'(MAX_STEPS - 1))
                    begin
                        state_reg <= S_WNEXT;
                    end
                end
                S_WNEXT:
                begin
                    state_reg <= vert_reg ? S_SQMUL : S_WSET;
                end
                S_SQMUL:
                begin
                    state_reg <= S_SQADD;
                end
                S_SQADD:
                begin
                    state_reg <= (sq_idx_reg == 2'd3) ? S_PICK : S_SQMUL;
                end
                S_PICK:
                begin
                    if (hh_reg || vh_reg)
                    begin
                        cor_start_reg <= 1'b1;
                        state_reg     <= S_CORR;
                    end
                    else
                    begin
                        state_reg <= S_EMIT;
                    end
                end
                S_CORR:
                begin
                    if (cor_rsp.done)
                    begin
                        state_reg <= S_ROOT;
                    end
                end
                S_ROOT:
                begin
                    if (rbit_reg[0])
                    begin
                        state_reg <= S_SCALE;
                    end
                end
                S_SCALE:
                begin
                    if (dshift == '0)
                    begin
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        div_start_reg <= 1'b1;
                        state_reg     <= S_HDIV;
                    end
                end
                S_HDIV:
                begin
                    if (div_rsp.done)
                    begin
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT:
                begin
                    if (!oq_full)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                desc_reg      <= rq_data;
                cor_angle_reg <= rq_data.ra;
                vert_reg      <= 1'b0;
                hh_reg        <= 1'b0;
                vh_reg        <= 1'b0;
                sqh_reg       <= '0;
                sqv_reg       <= '0;
                sq_idx_reg    <= '0;
            end
            S_TRIG:
            begin
                cs_reg <= cor_rsp.cs;
                sn_reg <= cor_rsp.sn;
            end
            S_WSET:
            begin
                pw_reg      <= pw_sel;
                u_reg       <= u0;
                fwd_reg     <= fwd;
                d0_reg      <= d0;
                neg_reg     <= (!fwd) ^ num_sel[TRIG_W-1] ^ den_sel[TRIG_W-1];
                num_abs_reg <= num_sel[TRIG_W-1] ? DIVD_W'(num_neg) : DIVD_W'(num_sel);
                den_abs_reg <= den_sel[TRIG_W-1] ? DIVD_W'(den_neg) : DIVD_W'(den_sel);
                step_reg    <= '0;
            end
            S_WMUL:
            begin
                div_num_reg <= a_prod[DIVN_W-1:0];
                div_den_reg <= den_abs_reg;
            end
            S_DIVA:
            begin
                if (div_rsp.done)
                begin
                    q_reg       <= QW'(div_rsp.quo);
                    r_reg       <= div_rsp.rem;
                    div_num_reg <= DIVN_W'(num_abs_reg) << CELL_SHIFT;
                end
            end
            S_DIVB:
            begin
                qb_reg <= div_rsp.quo;
                rb_reg <= div_rsp.rem;
            end
            S_WSTEP:
            begin
                if (wall)
                begin
                    if (vert_reg)
                    begin
                        vh_reg <= 1'b1;
                        vx_reg <= pt_x[COORD_W-1:0];
                        vy_reg <= pt_y[COORD_W-1:0];
                    end
                    else
                    begin
                        hh_reg <= 1'b1;
                        hx_reg <= pt_x[COORD_W-1:0];
                        hy_reg <= pt_y[COORD_W-1:0];
                    end
                end
                else
                begin
                    // advance to the next grid line
                    step_reg <= step_reg + 1'b1;
                    u_reg    <= fwd_reg ? u_reg + UW'(CELL) : u_reg - UW'(CELL);
                    r_reg    <= carry ? DIVD_W'(r_sum - {1'b0, den_abs_reg})
                                      : r_sum[DIVD_W-1:0];
                    q_reg    <= q_reg + QW'(qb_reg) + QW'(carry);
                end
            end
            S_WNEXT:
            begin
                vert_reg <= 1'b1;
            end
            S_SQMUL:
            begin
                prod_reg <= sq_full[31:0];
            end
            S_SQADD:
            begin
                if (!sq_idx_reg[1])
                begin
                    sqh_reg <= sqh_reg + SQW'(prod_reg);
                end
                else
                begin
                    sqv_reg <= sqv_reg + SQW'(prod_reg);
                end
                sq_idx_reg <= sq_idx_reg + 1'b1;
            end
            S_PICK:
            begin
                found_reg     <= hh_reg || vh_reg;
                cor_angle_reg <= desc_reg.corr;
                rr_reg        <= '0;
                rbit_reg      <= SQW'(1) << 32;
                dist_reg      <= '1;
                height_reg    <= '0;
                // ties go to the horizontal hit
                if (vh_reg && (!hh_reg || sqv_reg < sqh_reg))
                begin
                    vside_reg <= 1'b1;
                    rx_reg    <= vx_reg;
                    ry_reg    <= vy_reg;
                    rv_reg    <= sqv_reg;
                end
                else if (hh_reg)
                begin
                    vside_reg <= 1'b0;
                    rx_reg    <= hx_reg;
                    ry_reg    <= hy_reg;
                    rv_reg    <= sqh_reg;
                end
                else
                begin
                    vside_reg <= 1'b0;
                    rx_reg    <= desc_reg.px;
                    ry_reg    <= desc_reg.py;
                    rv_reg    <= '0;
                end
            end
            S_CORR:
            begin
                if (cor_rsp.cs < 0)
                begin
                    cc_reg <= '0;
                end
                else if (cor_rsp.cs > TRIG_W'(65536))
                begin
                    cc_reg <= DIVD_W'(65536);
                end
                else
                begin
                    cc_reg <= DIVD_W'(cor_rsp.cs);
                end
            end
            S_ROOT:
            begin
                if (rv_reg >= trial)
                begin
                    rv_reg <= rv_reg - trial;
                    rr_reg <= (rr_reg >> 1) + rbit_reg;
                end
                else
                begin
                    rr_reg <= rr_reg >> 1;
                end
                rbit_reg <= rbit_reg >> 2;
            end
            S_SCALE:
            begin
                dist_reg    <= dshift[16] ? '1 : dshift[DIST_W-1:0];
                height_reg  <= HGT_MAX_W'(VIEW_HEIGHT);
                div_num_reg <= HGT_NUM;
                div_den_reg <= dshift[16] ? DIVD_W'(17'h0FFFF) : dshift;
            end
            S_HDIV:
            begin
                height_reg <= (div_rsp.quo > DIVN_W'(VIEW_HEIGHT))
                              ? HGT_MAX_W'(VIEW_HEIGHT) : div_rsp.quo[HGT_MAX_W-1:0];
            end
            default:
            begin
                rr_reg <= rr_reg;
            end
        endcase
    end

endmodule

>>> hdl/grid_raycast_wall_columns.sv
// Top level of the grid ray caster: frame requests in, one wall column per ray out.
//
//  channel   | handshake         | payload
//  ----------+-------------------+-------------------------------------------------
//  request   | push / full       | player_x, player_y, view_angle
//  config    | cfg_we            | cfg_wdata (wall bitmap, bit row*8+column)
//  result    | empty / pop       | column, hit_x, hit_y, distance, hit_found,
//            |                   | vertical_side, wall_height, wall_offset, last
//
// One request yields RAY_COUNT results, left to right, the last one flagged.
// Each ray takes up to five passes of the shared divider (two per walk, one for the
// height), up to two CORDIC rotations, a square root and up to 2*MAX_STEPS grid steps.
// full stays high while the front hands out the rays of a frame; results drain
// through a two-entry queue, and a stalled pop holds the back end and, once the ray queue fills, the front.
// Reset clears the wall bitmap and all control state; no clearing pass.
module grid_raycast_wall_columns import grc_pkg::*; #(
    parameter int MAP_WIDTH   = 8,
    parameter int MAP_HEIGHT  = 8,
    parameter int RAY_COUNT   = 60,
    parameter int MAX_STEPS   = 8,
    parameter int VIEW_HEIGHT = 320,
    parameter int HEIGHT_W    = $clog2(VIEW_HEIGHT + 1),
    parameter int OFFSET_W    = $clog2(VIEW_HEIGHT / 2 + 1)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic [COORD_W-1:0]  player_x,
    input  logic [COORD_W-1:0]  player_y,
    input  logic [ANG_W-1:0]    view_angle,
    input  logic                cfg_we,
    input  logic [63:0]         cfg_wdata,
    output logic                empty,
    input  logic                pop,
    output logic [COL_W-1:0]    column,
    output logic [COORD_W-1:0]  hit_x,
    output logic [COORD_W-1:0]  hit_y,
    output logic [DIST_W-1:0]   distance,
    output logic                hit_found,
    output logic                vertical_side,
    output logic [HEIGHT_W-1:0] wall_height,
    output logic [OFFSET_W-1:0] wall_offset,
    output logic                last
);

    // wall bitmap; the user must write it only between frames, the block does not enforce this
    logic [63:0] map_walls_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_walls_reg <= '0;
        end
        else if (cfg_we)
        begin
            map_walls_reg <= cfg_wdata;
        end
    end

    // front: one request fans out into ray descriptors
    logic      rq_push;
    logic      rq_full;
    logic      rq_pop;
    logic      rq_empty;
    ray_desc_t rq_wdata;
    ray_desc_t rq_rdata;

    grc_front #(
        .RAY_COUNT (RAY_COUNT)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .player_x   (player_x),
        .player_y   (player_y),
        .view_angle (view_angle),
        .rq_push    (rq_push),
        .rq_data    (rq_wdata),
        .rq_full    (rq_full)
    );

    // decouple the ray generator from the tracer
    grc_fifo #(
        .WIDTH ($bits(ray_desc_t)),
        .DEPTH (2)
    ) u_ray_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (rq_push),
        .wdata (rq_wdata),
        .full  (rq_full),
        .pop   (rq_pop),
        .rdata (rq_rdata),
        .empty (rq_empty)
    );

    // back: trace each ray
    logic        oq_push;
    logic        oq_full;
    ray_result_t oq_wdata;
    ray_result_t oq_rdata;

    grc_back #(
        .MAP_WIDTH   (MAP_WIDTH),
        .MAP_HEIGHT  (MAP_HEIGHT),
        .MAX_STEPS   (MAX_STEPS),
        .VIEW_HEIGHT (VIEW_HEIGHT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .map_walls (map_walls_reg),
        .rq_empty  (rq_empty),
        .rq_data   (rq_rdata),
        .rq_pop    (rq_pop),
        .oq_full   (oq_full),
        .oq_push   (oq_push),
        .oq_data   (oq_wdata)
    );

    // hold finished columns until the consumer pops them
    grc_fifo #(
        .WIDTH ($bits(ray_result_t)),
        .DEPTH (2)
    ) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (oq_push),
        .wdata (oq_wdata),
        .full  (oq_full),
        .pop   (pop),
        .rdata (oq_rdata),
        .empty (empty)
    );

    assign column        = oq_rdata.column;
    assign hit_x         = oq_rdata.hit_x;
    assign hit_y         = oq_rdata.hit_y;
    assign distance      = oq_rdata.distance;
    assign hit_found     = oq_rdata.hit_found;
    assign vertical_side = oq_rdata.vertical_side;
    assign wall_height   = oq_rdata.wall_height[HEIGHT_W-1:0];
    assign wall_offset   = oq_rdata.wall_offset[OFFSET_W-1:0];
    assign last          = oq_rdata.last;

endmodule

>>> hdl/grc_checker.sv
// Port-level checks for the ray caster result stream, bound to the top level.
module grc_checker #(
    parameter int VIEW_HEIGHT = 320,
    parameter int HEIGHT_W    = $clog2(VIEW_HEIGHT + 1),
    parameter int OFFSET_W    = $clog2(VIEW_HEIGHT / 2 + 1)
) (
    input logic                clk,
    input logic                rst_n,
    input logic                empty,
    input logic                pop,
    input logic [15:0]         hit_x,
    input logic [15:0]         distance,
    input logic                hit_found,
    input logic                vertical_side,
    input logic [HEIGHT_W-1:0] wall_height,
    input logic [OFFSET_W-1:0] wall_offset
);

    // a column with no wall is blank and at full distance
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !hit_found) |-> (distance == 16'hFFFF && wall_height == '0))
    else $error("miss column not blank");

    // the top offset centers the clamped column
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (32'(wall_offset) + 32'(wall_height >> 1) == VIEW_HEIGHT / 2))
    else $error("wall offset does not center the column");

    // a vertical side only exists on a real hit
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && vertical_side) |-> hit_found)
    else $error("vertical side flagged without a hit");

    // a waiting result holds until popped
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(hit_x) && $stable(distance)))
    else $error("waiting result changed");

endmodule

bind grid_raycast_wall_columns grc_checker #(
    .VIEW_HEIGHT (VIEW_HEIGHT)
) u_grc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .empty         (empty),
    .pop           (pop),
    .hit_x         (hit_x),
    .distance      (distance),
    .hit_found     (hit_found),
    .vertical_side (vertical_side),
    .wall_height   (wall_height),
    .wall_offset   (wall_offset)
);
